// ----- rtl/extended_gcd_unit_defines.svh -----
// Assertion macros shared by the extended gcd unit.
`ifndef EXTENDED_GCD_UNIT_DEFINES_SVH
`define EXTENDED_GCD_UNIT_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent.
`define EGCD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define EGCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/egcd_pkg.sv -----
// Types, constants and helpers shared by the extended gcd unit.
package egcd_pkg;

    localparam int WIDTH  = 32;
    localparam int DW     = 32;
    localparam int CW     = 64;
    localparam int CNT_W  = $clog2(DW);
    localparam int EXT_SH = DW - WIDTH;

    localparam logic [1:0] MODE_GCD   = 2'd0;
    localparam logic [1:0] MODE_SOLVE = 2'd1;
    localparam logic [1:0] MODE_INV   = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
        logic signed [31:0] target_c;
    } req_t;

    typedef struct packed {
        logic signed [31:0] gcd_value;
        logic signed [63:0] coef_x;
        logic signed [63:0] coef_y;
        logic               ok;
    } rsp_t;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_LOAD,
        OP_SETUP_LOOP,
        OP_SETUP_POST,
        OP_DIV_BIT,
        OP_STEP,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic b_zero;
        logic post_div;
    } dp_status_t;

    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
        logic [DW-1:0] neg;
        neg = DW'(-v);
        return v[DW-1] ? neg : DW'(v);
    endfunction

    function automatic logic signed [DW-1:0] sext(input logic [31:0] v);
        logic [31:0] up;
        up = v << EXT_SH;
        return DW'($signed(up) >>> EXT_SH);
    endfunction

endpackage

// ----- rtl/egcd_div.sv -----
// Bit-serial restoring divider with quotient-driven product accumulators.
module egcd_div (
    input  logic                        clk,
    input  logic                        init,
    input  logic                        step,
    input  logic [egcd_pkg::DW-1:0]     dividend,
    input  logic [egcd_pkg::DW-1:0]     divisor,
    input  logic [egcd_pkg::CW-1:0]     mult_x,
    input  logic [egcd_pkg::CW-1:0]     mult_y,
    output logic [egcd_pkg::DW-1:0]     rem,
    output logic [egcd_pkg::CW-1:0]     prod_x,
    output logic [egcd_pkg::CW-1:0]     prod_y
);
    import egcd_pkg::*;

    logic [DW-1:0] dvd_reg, dvd_next;
    logic [DW-1:0] dsr_reg;
    logic [DW-1:0] rem_reg, rem_next;
    logic [CW-1:0] mx_reg, my_reg;
    logic [CW-1:0] px_reg, px_next;
    logic [CW-1:0] py_reg, py_next;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          qbit;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[DW-1]};
        diff     = trial - {1'b0, dsr_reg};
        qbit     = (trial >= {1'b0, dsr_reg});
        rem_next = qbit ? diff[DW-1:0] : trial[DW-1:0];
        dvd_next = dvd_reg << 1;
        px_next  = (px_reg << 1) + (qbit ? mx_reg : '0);
        py_next  = (py_reg << 1) + (qbit ? my_reg : '0);
    end

    always_ff @(posedge clk)
    begin
        if (init)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
            mx_reg  <= mult_x;
            my_reg  <= mult_y;
            px_reg  <= '0;
            py_reg  <= '0;
        end
        else if (step)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
            px_reg  <= px_next;
            py_reg  <= py_next;
        end
    end

    assign rem    = rem_reg;
    assign prod_x = px_reg;
    assign prod_y = py_reg;

endmodule

// ----- rtl/egcd_dp.sv -----
// Datapath of the extended gcd unit: operand, coefficient and result registers.
module egcd_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  egcd_pkg::req_t       request,
    input  egcd_pkg::dp_cmd_t    cmd,
    output egcd_pkg::dp_status_t status,
    output logic                 done,
    output egcd_pkg::rsp_t       result
);
    import egcd_pkg::*;

    localparam logic [DW-1:0] ONE_D = DW'(1);

    logic [1:0]           mode_reg;
    logic signed [DW-1:0] a_reg, b_reg, bin_reg, c_reg;
    logic [CW-1:0]        ox_reg, x_reg, oy_reg, y_reg;
    logic                 sa_reg, sa_next;
    rsp_t                 result_reg, result_next;
    logic                 done_reg;

    logic [DW-1:0] dvd, dsr, rem;
    logic [CW-1:0] mx, my, px, py;
    logic          neg;
    logic          g_one, g_mone, g_unit;
    logic [DW-1:0] v32;
    logic [DW-1:0] r_signed;
    logic          post_div;
    logic          div_init;

    assign g_one    = (a_reg == ONE_D);
    assign g_mone   = (&a_reg);
    assign g_unit   = g_one || g_mone;
    assign post_div = ((mode_reg == MODE_SOLVE) && (a_reg != '0)) ||
                      ((mode_reg == MODE_INV) && (bin_reg > 0) && g_unit);
    assign div_init = (cmd.op == OP_SETUP_LOOP) || (cmd.op == OP_SETUP_POST);
    assign v32      = g_one ? ox_reg[DW-1:0] : DW'(-ox_reg[DW-1:0]);
    assign r_signed = sa_reg ? DW'(-rem) : rem;

    always_comb
    begin
        dvd     = mag(a_reg);
        dsr     = mag(b_reg);
        neg     = a_reg[DW-1] ^ b_reg[DW-1];
        mx      = neg ? CW'(-x_reg) : x_reg;
        my      = neg ? CW'(-y_reg) : y_reg;
        sa_next = a_reg[DW-1];
        if (cmd.op == OP_SETUP_POST)
        begin
            if (mode_reg == MODE_SOLVE)
            begin
                dvd     = mag(c_reg);
                dsr     = mag(a_reg);
                neg     = c_reg[DW-1] ^ a_reg[DW-1];
                mx      = neg ? CW'(-ox_reg) : ox_reg;
                my      = neg ? CW'(-oy_reg) : oy_reg;
                sa_next = c_reg[DW-1];
            end
            else
            begin
                dvd     = mag(v32);
                dsr     = bin_reg;
                mx      = '0;
                my      = '0;
                sa_next = v32[DW-1];
            end
        end
    end

    egcd_div u_div (
        .clk      (clk),
        .init     (div_init),
        .step     (cmd.op == OP_DIV_BIT),
        .dividend (dvd),
        .divisor  (dsr),
        .mult_x   (mx),
        .mult_y   (my),
        .rem      (rem),
        .prod_x   (px),
        .prod_y   (py)
    );

    always_comb
    begin
        result_next           = '0;
        result_next.gcd_value = a_reg;
        case (mode_reg)
            MODE_GCD:
            begin
                result_next.ok     = 1'b1;
                result_next.coef_x = ox_reg;
                result_next.coef_y = oy_reg;
            end
            MODE_SOLVE:
            begin
                if (a_reg == '0)
                begin
                    result_next.ok = (c_reg == '0);
                end
                else if (rem == '0)
                begin
                    result_next.ok     = 1'b1;
                    result_next.coef_x = px;
                    result_next.coef_y = py;
                end
            end
            MODE_INV:
            begin
                if (post_div)
                begin
                    result_next.ok = 1'b1;
                    if (!sa_reg)
                        result_next.coef_x = CW'(rem);
                    else if (rem != '0)
                        result_next.coef_x = CW'(bin_reg - rem);
                end
            end
            default:
            begin
                result_next.ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                mode_reg <= request.mode;
                a_reg    <= sext(request.operand_a);
                b_reg    <= sext(request.operand_b);
                bin_reg  <= sext(request.operand_b);
                c_reg    <= sext(request.target_c);
                ox_reg   <= CW'(1);
                x_reg    <= '0;
                oy_reg   <= '0;
                y_reg    <= CW'(1);
            end
            OP_SETUP_LOOP, OP_SETUP_POST:
            begin
                sa_reg <= sa_next;
            end
            OP_STEP:
            begin
                a_reg  <= b_reg;
                b_reg  <= r_signed;
                ox_reg <= x_reg;
                x_reg  <= ox_reg - px;
                oy_reg <= y_reg;
                y_reg  <= oy_reg - py;
            end
            OP_FINISH:
            begin
                result_reg <= result_next;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= (cmd.op == OP_FINISH);
    end

    assign status.b_zero   = (b_reg == '0);
    assign status.post_div = post_div;
    assign done            = done_reg;
    assign result          = result_reg;

endmodule

// ----- rtl/egcd_ctrl.sv -----
// Sequencer of the extended gcd unit: Euclid loop, post divide and result issue.
`include "extended_gcd_unit_defines.svh"

module egcd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  egcd_pkg::dp_status_t status,
    output egcd_pkg::dp_cmd_t    cmd
);
    import egcd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SETUP_LOOP,
        S_RUN,
        S_STEP,
        S_POST,
        S_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             post_reg, post_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        post_next  = post_reg;
        cmd.op     = OP_IDLE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = status.b_zero ? S_POST : S_SETUP_LOOP;
            end
            S_SETUP_LOOP:
            begin
                cmd.op     = post_reg ? OP_SETUP_POST : OP_SETUP_LOOP;
                cnt_next   = CNT_W'(DW - 1);
                state_next = S_RUN;
            end
            S_RUN:
            begin
                cmd.op   = OP_DIV_BIT;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = post_reg ? S_FINISH : S_STEP;
            end
            S_STEP:
            begin
                cmd.op     = OP_STEP;
                state_next = S_CHECK;
            end
            S_POST:
            begin
                if (status.post_div)
                begin
                    post_next  = 1'b1;
                    state_next = S_SETUP_LOOP;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.op     = OP_FINISH;
                post_next  = 1'b0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            post_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            post_reg  <= post_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    `EGCD_ASSERT_NEXT(a_start_load, (state_reg == S_IDLE) && start, state_reg == S_CHECK, "transfer not taken")
    `EGCD_ASSERT_NEXT(a_run_count, (state_reg == S_RUN) && (cnt_reg != '0), (state_reg == S_RUN) && (cnt_reg == $past(cnt_reg) - 1'b1), "divide count slipped")
    `EGCD_ASSERT_NEXT(a_loop_step, (state_reg == S_RUN) && (cnt_reg == '0) && !post_reg, state_reg == S_STEP, "loop divide did not step")
    `EGCD_ASSERT_SAME(a_post_run, (state_reg == S_RUN) && post_reg, status.post_div, "post divide without cause")
    `EGCD_ASSERT_NEXT(a_finish_idle, state_reg == S_FINISH, (state_reg == S_IDLE) && !post_reg, "finish did not release")

endmodule

// ----- rtl/extended_gcd_unit.sv -----
// Top level of the extended gcd unit: controller and datapath.
//
// Usage: drive request and raise start while busy is low; the request is
// transferred at that clock edge and busy rises in the next cycle. The unit
// runs the extended Euclid loop with truncating signed division and returns
// one result per request: done is high for exactly one cycle with result
// valid in that cycle. The receiver cannot stall, so capture it then.
// Each Euclid step tests b, sets up and runs a bit-serial divide, which also
// accumulates quotient times coefficient, then updates the registers. A
// request takes at most 45 steps on 32-bit operands, plus a second divide
// when the solve or inverse mode needs one. One request is in flight
// at a time, and a new start is taken in the cycle done is high.
// Reset (rst_n low, asynchronous) returns the controller to idle and drops
// any request in progress; no result is issued for it.
module extended_gcd_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  egcd_pkg::req_t  request,
    output logic            done,
    output egcd_pkg::rsp_t  result
);
    import egcd_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    egcd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    egcd_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .status  (status),
        .done    (done),
        .result  (result)
    );

endmodule
